>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, codes and constants of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   localparam int KEY_W            = 32;
   localparam int MODE_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int POSITION_W       = 8;
   localparam int ENTRIES_W        = 9;

   // Operation codes carried in a request.
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [POSITION_W-1:0] position;
      logic [ENTRIES_W-1:0]  entries;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // take the request, open the search window
      logic probe_cmp;  // compare the probed key and narrow the window
      logic decide;     // settle the outcome and set up the move pointer
      logic rd_move;    // read address comes from the move pointer
      logic move_wr;    // write the moved key and step the pointer
      logic commit;     // place an inserted key, adjust the entry count
      logic load_rsp;   // load the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_open;  // search window is not yet empty
      logic mutate;       // the request changes the table
      logic move_more;    // keys remain to be moved
      logic out_free;     // output register can take a result
   } stat_type;

endpackage

>>> rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for search, key moves, commit and result hand-off.
// ----------------------------------------------------------------------------
module skt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  skt_pkg::stat_type stat,
   output skt_pkg::cmd_type  cmd
);
   import skt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_PROBE_RD  = 8'b0000_0010,
      S_PROBE_CMP = 8'b0000_0100,
      S_DECIDE    = 8'b0000_1000,
      S_MOVE_RD   = 8'b0001_0000,
      S_MOVE_WR   = 8'b0010_0000,
      S_COMMIT    = 8'b0100_0000,
      S_RESPOND   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            state_in = stat.search_open ? S_PROBE_CMP : S_DECIDE;
         end
         S_PROBE_CMP: begin
            cmd.probe_cmp = 1'b1;
            state_in      = S_PROBE_RD;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.mutate ? S_MOVE_RD : S_RESPOND;
         end
         S_MOVE_RD: begin
            cmd.rd_move = 1'b1;
            state_in    = stat.move_more ? S_MOVE_WR : S_COMMIT;
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            state_in    = S_MOVE_RD;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> rtl/skt_dpath.sv
// ----------------------------------------------------------------------------
// skt_dpath
// Key storage, search window, move pointer, entry count and output register.
// ----------------------------------------------------------------------------
module skt_dpath #(
   parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  skt_pkg::req_type  req_data,
   input  skt_pkg::cmd_type  cmd,
   output skt_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skt_pkg::rsp_type  rsp_data
);
   import skt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [MODE_W-1:0]       mode_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CW-1:0]           lo_ff;
   logic [CW-1:0]           hi_ff;
   logic                    hit_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           ptr_ff;
   logic                    ins_ff;
   logic                    del_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [CW:0]         sum;
   logic [CW-1:0]       mid;
   logic [KEY_W-1:0]    rdata;
   logic [AW-1:0]       raddr;
   logic                we;
   logic [AW-1:0]       waddr;
   logic [KEY_W-1:0]    wdata;
   logic                full;
   logic                do_ins;
   logic                do_del;
   logic [STATUS_W-1:0] status_in;
   logic [CW-1:0]       ptr_dec;
   logic [CW-1:0]       ptr_inc;
   logic                out_free;

   assign sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = sum[CW:1];
   assign ptr_dec = ptr_ff - CW'(1);
   assign ptr_inc = ptr_ff + CW'(1);
   assign full    = (count_ff == CAP_COUNT);

   // Insert reads the key below the pointer, delete the key above it.
   always_comb begin
      if (cmd.rd_move) begin
         raddr = ins_ff ? ptr_dec[AW-1:0] : ptr_inc[AW-1:0];
      end else begin
         raddr = mid[AW-1:0];
      end
   end

   assign we    = cmd.move_wr | (cmd.commit & ins_ff);
   assign waddr = cmd.commit ? lo_ff[AW-1:0] : ptr_ff[AW-1:0];
   assign wdata = cmd.commit ? key_ff : rdata;

   skt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign do_ins = (mode_ff == MODE_INSERT) && !hit_ff && !full;
   assign do_del = (mode_ff == MODE_DELETE) && hit_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_LOOKUP: status_in = hit_ff ? STATUS_OK : STATUS_MISS;
         MODE_INSERT: status_in = hit_ff ? STATUS_DUP : (full ? STATUS_FULL : STATUS_OK);
         MODE_DELETE: status_in = hit_ff ? STATUS_OK : STATUS_MISS;
         default:     status_in = STATUS_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_data.mode;
         key_ff  <= req_data.key;
         lo_ff   <= '0;
         hi_ff   <= count_ff;
         hit_ff  <= 1'b0;
      end
      if (cmd.probe_cmp) begin
         if ($signed(rdata) < key_ff) begin
            lo_ff <= mid + CW'(1);
         end else begin
            hi_ff <= mid;
         end
         if ($signed(rdata) == key_ff) begin
            hit_ff <= 1'b1;
         end
      end
      if (cmd.decide) begin
         ins_ff    <= do_ins;
         del_ff    <= do_del;
         status_ff <= status_in;
         ptr_ff    <= do_ins ? count_ff : lo_ff;
      end
      if (cmd.move_wr) begin
         ptr_ff <= ins_ff ? ptr_dec : ptr_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         if (ins_ff) begin
            count_ff <= count_ff + CW'(1);
         end else if (del_ff) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // Output register: a finished result waits here while the next request runs.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status   <= status_ff;
         rsp_ff.position <= (status_ff == STATUS_OK) ? POSITION_W'(lo_ff) : '0;
         rsp_ff.entries  <= ENTRIES_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat.search_open = (lo_ff < hi_ff);
      stat.mutate      = do_ins || do_del;
      stat.move_more   = ins_ff ? (ptr_ff > lo_ff)
                                : (({1'b0, ptr_ff} + (CW+1)'(1)) < {1'b0, count_ff});
      stat.out_free    = out_free;
   end

endmodule

>>> rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Ordered table of distinct signed 32-bit keys with lookup, insert, delete.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries a mode (lookup, insert or delete)
// and a signed key. Exactly one result leaves on the rsp_ channel for every
// request, in order, carrying a status, the position of the key and the
// number of keys held after the operation.
// Requests are handled one at a time. The binary search makes at most
// P = ceil(log2(N+1)) probes over N held keys, each an address step, then
// a compare of the registered read data. An insert or a delete that changes
// the table also moves keys one slot through the RAM: an insert moves every
// key from the insert position up, a delete every key above the deleted
// one. After the last move the commit places an inserted key and adjusts
// the entry count. req_stall is high from the cycle after a request is
// taken until the result is loaded, so the next request can be taken in
// the cycle after that.
// Reset empties the table at once; no clearing pass is needed because only
// slots below the entry count are ever read. While rsp_stall holds the output,
// the next request is still accepted and processed; it only waits at the end
// until the output register is free.
// ----------------------------------------------------------------------------
module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  skt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output skt_pkg::rsp_type rsp_data
);
   import skt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences search, moves and commit.
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the keys, the search window and the output register.
   skt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks of the sorted key table, bound to its top level.
// ----------------------------------------------------------------------------
module skt_checker #(
   parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input skt_pkg::rsp_type rsp_data
);
   import skt_pkg::*;

   localparam logic [ENTRIES_W-1:0] CAP_ENTRIES = ENTRIES_W'(CAPACITY);

   // A held result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A taken request keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after acceptance");

   // A new result appears only from a busy block.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a request in progress");

   // A full table reports the capacity as its entry count.
   a_full_entries: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |-> rsp_data.entries == CAP_ENTRIES)
      else $error("table full with wrong entry count");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_key_table skt_checker #(
   .CAPACITY (CAPACITY)
) u_skt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
